// ===== rtl/dqrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqrd_pkg
// Shared types and constants for the deque engine with lazy reverse.
// ----------------------------------------------------------------------------
package dqrd_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_REVERSE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_FINISH  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_done;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/dqrd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqrd_ctrl
// Controller: accepts commands and sequences the emission of a finished list.
// ----------------------------------------------------------------------------
module dqrd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    operation,
    input  wire dqrd_pkg::stat_t stat,
    output dqrd_pkg::cmd_t     cmd
);
    import dqrd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op_t'(operation) == OP_FINISH)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.emit_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dqrd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqrd_datapath
// Element store, head and tail counters, direction and error flags, and the
// output word register fed straight from the store's registered read port.
// ----------------------------------------------------------------------------
module dqrd_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dqrd_pkg::cmd_t                     cmd,
    output dqrd_pkg::stat_t                         stat,
    input  wire logic [1:0]                         operation,
    input  wire logic signed [dqrd_pkg::DATA_W-1:0] element_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [dqrd_pkg::DATA_W-1:0]      out_value,
    output logic                                    is_error,
    output logic                                    is_empty,
    output logic                                    is_last
);
    import dqrd_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rev_reg, rev_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              out_err_reg, out_empty_reg, out_last_reg;

    logic [CNT_W-1:0]  end_pos;
    logic [CNT_W-1:0]  live_cnt;
    logic [CNT_W-1:0]  rd_pos;
    logic              wr_en;
    logic              elem_last;
    logic              marker;

    assign end_pos   = loaded_reg - tail_reg;
    assign live_cnt  = loaded_reg - head_reg - tail_reg;
    assign rd_pos    = rev_reg ? (end_pos - CNT_W'(1) - idx_reg) : (head_reg + idx_reg);
    assign elem_last = (idx_reg + CNT_W'(1)) == live_cnt;
    assign marker    = err_reg || (live_cnt == '0);
    assign wr_en     = cmd.exec && (op_t'(operation) == OP_APPEND) && !err_reg
                       && (end_pos < CNT_W'(DEPTH));

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.emit_done = marker || elem_last;

    always_comb
    begin
        loaded_next    = loaded_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        idx_next       = idx_reg;
        rev_next       = rev_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.exec && !err_reg)
        begin
            case (op_t'(operation))
                OP_APPEND:
                begin
                    if (end_pos >= CNT_W'(DEPTH))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        loaded_next = end_pos + CNT_W'(1);
                        tail_next   = '0;
                    end
                end
                OP_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                OP_DELETE:
                begin
                    if (live_cnt == '0)
                    begin
                        err_next = 1'b1;
                    end
                    else if (rev_reg)
                    begin
                        tail_next = tail_reg + CNT_W'(1);
                    end
                    else
                    begin
                        head_next = head_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + CNT_W'(1);
            if (stat.emit_done)
            begin
                loaded_next = '0;
                head_next   = '0;
                tail_next   = '0;
                idx_next    = '0;
                rev_next    = 1'b0;
                err_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            idx_reg       <= '0;
            rev_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            idx_reg       <= idx_next;
            rev_reg       <= rev_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[end_pos[ADDR_W-1:0]] <= element_value;
        end
        if (cmd.emit)
        begin
            if (marker)
            begin
                rd_data_reg <= '0;
            end
            else
            begin
                rd_data_reg <= mem[rd_pos[ADDR_W-1:0]];
            end
            out_err_reg   <= err_reg;
            out_empty_reg <= !err_reg && (live_cnt == '0);
            out_last_reg  <= stat.emit_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = rd_data_reg;
    assign is_error  = out_err_reg;
    assign is_empty  = out_empty_reg;
    assign is_last   = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && cmd.emit))
        else $error("Command and emission issued in the same cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !err_reg |-> ({1'b0, head_reg} + {1'b0, tail_reg} <= {1'b0, loaded_reg}))
        else $error("Removed elements exceed loaded elements.");

    assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(DEPTH))
        else $error("Loaded count beyond store depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.emit_done) |=> (loaded_reg == '0 && !err_reg && idx_reg == '0))
        else $error("State not cleared after the final word.");

endmodule
`default_nettype wire

// ===== rtl/deque_reverse_delete_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deque_reverse_delete_engine_core
// Double-ended list engine with a lazy reverse and an emitting finish command.
// ----------------------------------------------------------------------------
// Usage: input words carry an operation and a value on a valid/ready channel.
// Append, reverse and delete produce no output word; append writes one store
// entry and delete moves a head or tail counter. A finish word stops input
// for its run: the controller then issues one store read per cycle while the
// receiver is free, and each registered read becomes an output word. An error
// or empty list gives a single marker word. The last word of each run is
// flagged, and the engine clears its state when that word is issued, ready
// for the next list at once. The store read port sets the pace of one word
// per cycle. When the receiver stalls, the output word holds and no further
// read is issued. Reset clears the counters and the direction, error and
// valid flags; the store contents and the output word and flag registers
// are left as they are.
// ----------------------------------------------------------------------------
module deque_reverse_delete_engine_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         operation,
    input  wire logic signed [dqrd_pkg::DATA_W-1:0] element_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [dqrd_pkg::DATA_W-1:0]      out_value,
    output logic                                    is_error,
    output logic                                    is_empty,
    output logic                                    is_last
);
    import dqrd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    dqrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    dqrd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_value     (out_value),
        .is_error      (is_error),
        .is_empty      (is_empty),
        .is_last       (is_last)
    );

endmodule
`default_nettype wire
